// ===== rtl/spb_pkg.sv =====
// ----------------------------------------------------------------------------
// spb_pkg
// shared types and constants of the shortest palindrome builder
// ----------------------------------------------------------------------------
`default_nettype none

package spb_pkg;

  localparam int CHAR_W = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_MIRROR,
    ST_PROBE,
    ST_CHECK,
    ST_PLAN,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/spb_char_mem.sv =====
// ----------------------------------------------------------------------------
// spb_char_mem
// byte store of the string: one write port, two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module spb_char_mem #(
  parameter int MAX_LEN = 32,
  localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [ADDR_W-1:0]          waddr,
  input  wire logic [spb_pkg::CHAR_W-1:0] wdata,
  input  wire logic                       re,
  input  wire logic [ADDR_W-1:0]          raddr_a,
  input  wire logic [ADDR_W-1:0]          raddr_b,
  output logic      [spb_pkg::CHAR_W-1:0] q_a,
  output logic      [spb_pkg::CHAR_W-1:0] q_b
);
  import spb_pkg::*;

  logic [CHAR_W-1:0] mem [MAX_LEN];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // both ports read together; the data arrives in the following cycle
  always_ff @(posedge clk) begin
    if (re) begin
      q_a <= mem[raddr_a];
      q_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/shortest_palindrome_builder.sv =====
// ----------------------------------------------------------------------------
// shortest_palindrome_builder
// builds the shortest palindrome by prepending bytes to a stored string
// ----------------------------------------------------------------------------
// usage
//   input: a byte transfer happens on a rising edge with start high and busy
//   low. bytes are stored one per cycle; last_in marks the final byte. bytes
//   beyond MAX_LEN are dropped and flagged on overflow of every result.
//   after the final byte busy rises while the block runs a manacher pass over
//   the separated string (2n+1 positions). each position takes a seed step,
//   a mirror step when it reuses a mirror radius, and a probe and a check
//   step per compare (a char store read, then the check). the radii live in
//   a synchronous memory, written at a position's end and read only for
//   later positions. the pass ends in a planning step, then one byte per
//   cycle is read out: the bytes after the longest palindromic prefix in
//   reverse, then the whole string. valid strobes each result for exactly
//   one cycle, the final one with last_out; the receiver cannot stall, so
//   emission never pauses. the first result follows the planning step
//   through the read-out state and the registered char store read; the last
//   one comes with busy already low in the same cycle. busy stays high through
//   the pass and a read-out of n to 2n-1 result bytes for a string of n bytes.
//   reset (synchronous, active high) clears the fill count, the overflow
//   flag, the state and the strobe; the stores need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module shortest_palindrome_builder #(
  parameter int MAX_LEN = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [spb_pkg::CHAR_W-1:0] char_in,
  input  wire logic                       last_in,
  output logic                            valid,
  output logic      [spb_pkg::CHAR_W-1:0] char_out,
  output logic                            last_out,
  output logic                            overflow
);
  import spb_pkg::*;

  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int ADDR_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int RAD_DEPTH = 2 * MAX_LEN + 2;
  localparam int RAD_AW    = $clog2(RAD_DEPTH);
  localparam int POS_W     = $clog2(2 * MAX_LEN + 3);

  // control state
  state_t state, state_next;
  logic [CNT_W-1:0] count;
  logic             ovf;

  // string length and manacher pass registers
  logic [CNT_W-1:0] n;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] rad;
  logic [POS_W-1:0] center;
  logic [POS_W-1:0] right;
  logic [POS_W-1:0] best;
  logic             chk_inr;   // both probe positions inside the separated string
  logic             chk_sep;   // both probe positions are separators

  // emission registers
  logic [CNT_W-1:0]  pre;
  logic [ADDR_W-1:0] k;
  logic              rev;

  // radius memory
  logic [POS_W-1:0] rad_mem [RAD_DEPTH];
  logic [POS_W-1:0] rad_q;
  logic             rad_re;
  logic             rad_we;
  logic [RAD_AW-1:0] rad_raddr;

  // char store port signals
  logic              cm_we;
  logic              cm_re;
  logic [ADDR_W-1:0] cm_raddr_a;
  logic [ADDR_W-1:0] cm_raddr_b;
  logic [CHAR_W-1:0] cm_q_a;
  logic [CHAR_W-1:0] cm_q_b;

  // derived values
  logic              accept;
  logic [POS_W-1:0]  tlen;        // 2n+2
  logic [POS_W-1:0]  last_pos;    // 2n+1
  logic [POS_W:0]    mirror;
  logic [POS_W-1:0]  lim;
  logic [POS_W-1:0]  probe_a;
  logic [POS_W:0]    probe_b;
  logic [POS_W:0]    reach;
  logic              match;
  logic [CNT_W-1:0]  n_m1;
  logic              emit_done;
  logic              rev_done;

  assign accept   = start && !busy;
  assign tlen     = (POS_W'(n) << 1) + POS_W'(2);
  assign last_pos = (POS_W'(n) << 1) + POS_W'(1);
  assign mirror   = ({1'b0, center} << 1) - {1'b0, pos};
  assign lim      = right - pos;
  assign probe_a  = pos - rad;
  assign probe_b  = {1'b0, pos} + {1'b0, rad};
  assign reach    = {1'b0, pos} + {1'b0, rad};
  assign match    = chk_inr && (chk_sep || (cm_q_a == cm_q_b));
  assign n_m1     = n - CNT_W'(1);
  assign emit_done = !rev && (CNT_W'(k) == n_m1);
  assign rev_done  = rev && (CNT_W'(k) == pre);

  spb_char_mem #(
    .MAX_LEN(MAX_LEN)
  ) u_char_mem (
    .clk    (clk),
    .we     (cm_we),
    .waddr  (ADDR_W'(count)),
    .wdata  (char_in),
    .re     (cm_re),
    .raddr_a(cm_raddr_a),
    .raddr_b(cm_raddr_b),
    .q_a    (cm_q_a),
    .q_b    (cm_q_b)
  );

  assign char_out = cm_q_a;

  // radius memory: written when a position settles, read for its mirror
  always_ff @(posedge clk) begin
    if (rad_we) begin
      rad_mem[RAD_AW'(pos)] <= rad;
    end
  end

  always_ff @(posedge clk) begin
    if (rad_re) begin
      rad_q <= rad_mem[rad_raddr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && last_in) begin
          state_next = ST_SEED;
        end
      end
      ST_SEED: begin
        state_next = (pos < right) ? ST_MIRROR : ST_PROBE;
      end
      ST_MIRROR: state_next = ST_PROBE;
      ST_PROBE:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (match) begin
          state_next = ST_PROBE;
        end else if (pos == last_pos) begin
          state_next = ST_PLAN;
        end else begin
          state_next = ST_SEED;
        end
      end
      ST_PLAN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs and memory ports
  always_comb begin
    busy       = (state != ST_IDLE);
    cm_we      = 1'b0;
    cm_re      = 1'b0;
    cm_raddr_a = k;
    cm_raddr_b = k;
    rad_re     = 1'b0;
    rad_we     = 1'b0;
    rad_raddr  = RAD_AW'(mirror);
    unique case (state)
      ST_IDLE: begin
        cm_we = accept && (count < CNT_W'(MAX_LEN));
      end
      ST_SEED: begin
        rad_re = (pos < right);
      end
      ST_PROBE: begin
        // even text position p holds byte (p-2)/2; stray addresses are masked later
        cm_re      = 1'b1;
        cm_raddr_a = ADDR_W'((probe_a - POS_W'(2)) >> 1);
        cm_raddr_b = ADDR_W'((probe_b - (POS_W + 1)'(2)) >> 1);
      end
      ST_CHECK: begin
        rad_we = !match;
      end
      ST_EMIT: begin
        cm_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      ovf   <= 1'b0;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      valid <= (state == ST_EMIT);
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (count < CNT_W'(MAX_LEN)) begin
              count <= count + CNT_W'(1);
              n     <= count + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
              n   <= count;
            end
            pos    <= POS_W'(1);
            center <= '0;
            right  <= '0;
            best   <= '0;
          end
        end
        ST_SEED: begin
          if (!(pos < right)) begin
            rad <= POS_W'(1);
          end
        end
        ST_MIRROR: begin
          rad <= (rad_q > lim) ? lim : rad_q;
        end
        ST_PROBE: begin
          chk_inr <= (probe_a != '0) && (probe_b < {1'b0, tlen});
          chk_sep <= probe_a[0];
        end
        ST_CHECK: begin
          if (match) begin
            rad <= rad + POS_W'(1);
          end else begin
            if ({1'b0, right} < reach) begin
              center <= pos;
              right  <= POS_W'(reach);
            end
            // radius touching the left border gives a palindromic prefix
            if ((probe_a < POS_W'(2)) && (rad > best)) begin
              best <= rad;
            end
            pos <= pos + POS_W'(1);
          end
        end
        ST_PLAN: begin
          if (best < POS_W'(2)) begin
            pre <= CNT_W'(1);
            rev <= (CNT_W'(1) < n);
            k   <= (CNT_W'(1) < n) ? ADDR_W'(n_m1) : '0;
          end else begin
            pre <= CNT_W'(best - POS_W'(1));
            rev <= (CNT_W'(best - POS_W'(1)) < n);
            k   <= (CNT_W'(best - POS_W'(1)) < n) ? ADDR_W'(n_m1) : '0;
          end
        end
        ST_EMIT: begin
          last_out <= emit_done;
          overflow <= ovf;
          if (rev_done) begin
            rev <= 1'b0;
            k   <= '0;
          end else if (rev) begin
            k <= k - ADDR_W'(1);
          end else if (emit_done) begin
            count <= '0;
            ovf   <= 1'b0;
          end else begin
            k <= k + ADDR_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // a result only follows a read-out cycle
  a_valid_after_emit: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(state == ST_EMIT))
    else $error("result strobe without a read-out cycle");

  // the compare step always sees the read data of a probe issued just before
  a_check_after_probe: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> $past(state == ST_PROBE))
    else $error("compare without a preceding probe read");

  // fill count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_LEN))
    else $error("fill count beyond store depth");

  // the final byte of a palindrome returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (valid && last_out) |-> (state == ST_IDLE && count == '0 && !ovf))
    else $error("final result without return to idle");

endmodule

`default_nettype wire
